// File: sv/dmadb_pkg.sv
// Types and constants shared by the descriptor builder files.
`timescale 1ns / 1ps
package dmadb_pkg;

    localparam int unsigned MaxResults = 4;
    localparam int unsigned ResIdxW    = 2;
    localparam int unsigned ResCntW    = 3;
    localparam int unsigned MaxChunks  = 3;

    localparam logic [17:0] WindowBytes  = 18'h10000;
    localparam logic [15:0] WindowMask   = 16'hffff;
    localparam logic [17:0] HardSegLimit = 18'd131072;

    typedef enum logic [1:0] {
        ST_DESC     = 2'd0,
        ST_OVERFLOW = 2'd1,
        ST_EMPTY    = 2'd2
    } t_status;

    typedef struct packed {
        logic [31:0] seg_addr;
        logic [17:0] seg_bytes;
        logic        seg_last;
    } t_seg;

    typedef struct packed {
        logic [31:0] entry_addr;
        logic [16:0] entry_bytes;
        logic        end_of_table;
        t_status     status;
        logic        run_last;
    } t_res;

    typedef struct packed {
        logic [31:0] open_start;
        logic [16:0] open_len;
        logic [31:0] open_end;
        logic        open_valid;
        logic        open_sealed;
        logic        req_failed;
    } t_state;

endpackage

// File: sv/dmadb_seg_if.sv
// Segment input channel: valid/ready handshake with segment payload.
`timescale 1ns / 1ps
interface dmadb_seg_if;
    logic        valid;
    logic        ready;
    logic [31:0] seg_addr;
    logic [17:0] seg_bytes;
    logic        seg_last;

    modport source (output valid, output seg_addr, output seg_bytes, output seg_last,
                    input ready);
    modport sink   (input valid, input seg_addr, input seg_bytes, input seg_last,
                    output ready);
endinterface

// File: sv/dmadb_entry_if.sv
// Descriptor result channel: valid/ready handshake with result payload.
`timescale 1ns / 1ps
interface dmadb_entry_if;
    logic        valid;
    logic        ready;
    logic [31:0] entry_addr;
    logic [16:0] entry_bytes;
    logic        end_of_table;
    logic [1:0]  status;
    logic        run_last;

    modport source (output valid, output entry_addr, output entry_bytes,
                    output end_of_table, output status, output run_last, input ready);
    modport sink   (input valid, input entry_addr, input entry_bytes,
                    input end_of_table, input status, input run_last, output ready);
endinterface

// File: sv/dma_descriptor_builder.sv
// Path: an accepted segment is registered in the input stage, then its results are loaded
// into the result buffer once that is free, and are offered from there.
// Throughput: one result per cycle on the single result port while the sink is ready.
// A new segment is taken while the previous one's last result is being handed over.
// Reset: synchronous, active low; clears the open descriptor, entry count and buffer occupancy.
// Top level of the scatter-gather descriptor builder.
`timescale 1ns / 1ps
module dma_descriptor_builder #(
    parameter int unsigned TABLE_ENTRIES     = 256,
    parameter int unsigned MAX_SEGMENT_BYTES = 131072
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    dmadb_seg_if.sink    i_seg,
    dmadb_entry_if.source o_entry
);
    import dmadb_pkg::*;

    localparam int unsigned UsedW = $clog2(TABLE_ENTRIES);

    t_seg                  r_in;
    logic                  r_in_valid;
    t_state                r_state;
    logic [UsedW-1:0]      r_used;

    t_state                n_state;
    logic [UsedW-1:0]      n_used;
    t_res [MaxResults-1:0] res;
    logic [ResCntW-1:0]    res_count;
    logic                  buf_free;
    logic                  consume;
    logic                  in_take;

    assign consume     = r_in_valid && buf_free;
    assign i_seg.ready = !r_in_valid || buf_free;
    assign in_take     = i_seg.valid && i_seg.ready;

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in <= '{seg_addr: i_seg.seg_addr, seg_bytes: i_seg.seg_bytes,
                      seg_last: i_seg.seg_last};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_state    <= '0;
            r_used     <= '0;
        end else begin
            if (in_take) begin
                r_in_valid <= 1'b1;
            end else if (consume) begin
                r_in_valid <= 1'b0;
            end
            if (consume) begin
                r_state <= n_state;
                r_used  <= n_used;
            end
        end
    end

    dmadb_build #(
        .TABLE_ENTRIES     (TABLE_ENTRIES),
        .MAX_SEGMENT_BYTES (MAX_SEGMENT_BYTES),
        .UsedW             (UsedW)
    ) u_build (
        .i_seg   (r_in),
        .i_state (r_state),
        .i_used  (r_used),
        .o_res   (res),
        .o_count (res_count),
        .o_state (n_state),
        .o_used  (n_used)
    );

    dmadb_result_buf u_result_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (consume),
        .i_res   (res),
        .i_count (res_count),
        .o_free  (buf_free),
        .o_entry (o_entry)
    );

endmodule

// File: sv/dmadb_build.sv
// Single-pass split/merge of one segment into up to four results and next state.
`timescale 1ns / 1ps
module dmadb_build #(
    parameter int unsigned TABLE_ENTRIES     = 256,
    parameter int unsigned MAX_SEGMENT_BYTES = 131072,
    parameter int unsigned UsedW             = $clog2(TABLE_ENTRIES)
) (
    input  dmadb_pkg::t_seg                            i_seg,
    input  dmadb_pkg::t_state                          i_state,
    input  logic [UsedW-1:0]                           i_used,
    output dmadb_pkg::t_res [dmadb_pkg::MaxResults-1:0] o_res,
    output logic [dmadb_pkg::ResCntW-1:0]              o_count,
    output dmadb_pkg::t_state                          o_state,
    output logic [UsedW-1:0]                           o_used
);
    import dmadb_pkg::*;

    localparam logic [17:0] SegLimit = (MAX_SEGMENT_BYTES < 131072) ?
                                       18'(MAX_SEGMENT_BYTES) : HardSegLimit;
    localparam logic [UsedW-1:0] UsedLimit = UsedW'(TABLE_ENTRIES - 1);

    logic [17:0] rem;
    logic [17:0] room;
    logic [17:0] rem2;
    logic        one_chunk;
    logic        two_chunk;
    logic [1:0]  n_chunks;
    logic [31:0] c_addr [MaxChunks];
    logic [16:0] c_take [MaxChunks];

    // chunk boundaries: first partial window, then at most one full and one tail
    always_comb begin
        rem       = (i_seg.seg_bytes > SegLimit) ? SegLimit : i_seg.seg_bytes;
        room      = WindowBytes - {2'b00, i_seg.seg_addr[15:0]};
        one_chunk = rem <= room;
        rem2      = rem - room;
        two_chunk = rem2 <= WindowBytes;
        c_addr[0] = i_seg.seg_addr;
        c_addr[1] = {i_seg.seg_addr[31:16] + 16'd1, 16'h0000};
        c_addr[2] = {i_seg.seg_addr[31:16] + 16'd2, 16'h0000};
        c_take[0] = one_chunk ? rem[16:0] : room[16:0];
        c_take[1] = two_chunk ? rem2[16:0] : WindowBytes[16:0];
        c_take[2] = 17'(rem2 - WindowBytes);
        if (rem == 18'd0) begin
            n_chunks = 2'd0;
        end else if (one_chunk) begin
            n_chunks = 2'd1;
        end else if (two_chunk) begin
            n_chunks = 2'd2;
        end else begin
            n_chunks = 2'd3;
        end
    end

    always_comb begin
        t_state                         st;
        logic [UsedW-1:0]               used;
        logic [ResCntW-1:0]             cnt;
        t_res [MaxResults-1:0]          res;

        st   = i_state;
        used = i_used;
        cnt  = '0;
        res  = '0;

        if (!st.req_failed) begin
            if (rem == 18'd0 && st.open_valid && i_seg.seg_addr != st.open_end) begin
                st.open_sealed = 1'b1;
            end
            for (int k = 0; k < MaxChunks; k++) begin
                if (2'(k) < n_chunks && !st.req_failed) begin
                    if (k == 0 && st.open_valid && !st.open_sealed &&
                        i_seg.seg_addr == st.open_end &&
                        (st.open_end[15:0] & WindowMask) != 16'h0000) begin
                        st.open_len = st.open_len + c_take[k];
                    end else if (used >= UsedLimit) begin
                        st.open_valid = 1'b0;
                        st.req_failed = 1'b1;
                        res[cnt[ResIdxW-1:0]] = '{entry_addr: '0, entry_bytes: '0,
                                                  end_of_table: 1'b0,
                                                  status: ST_OVERFLOW, run_last: 1'b0};
                        cnt = cnt + 3'd1;
                    end else begin
                        if (st.open_valid) begin
                            res[cnt[ResIdxW-1:0]] = '{entry_addr: st.open_start,
                                                      entry_bytes: st.open_len,
                                                      end_of_table: 1'b0,
                                                      status: ST_DESC, run_last: 1'b0};
                            cnt = cnt + 3'd1;
                        end
                        used           = used + UsedW'(1);
                        st.open_start  = c_addr[k];
                        st.open_len    = c_take[k];
                        st.open_valid  = 1'b1;
                        st.open_sealed = 1'b0;
                    end
                end
            end
            st.open_end = st.open_start + 32'(st.open_len);
        end

        if (i_seg.seg_last) begin
            if (!st.req_failed) begin
                if (st.open_valid) begin
                    res[cnt[ResIdxW-1:0]] = '{entry_addr: st.open_start,
                                              entry_bytes: st.open_len,
                                              end_of_table: 1'b1,
                                              status: ST_DESC, run_last: 1'b0};
                end else begin
                    res[cnt[ResIdxW-1:0]] = '{entry_addr: '0, entry_bytes: '0,
                                              end_of_table: 1'b0,
                                              status: ST_EMPTY, run_last: 1'b0};
                end
                cnt = cnt + 3'd1;
            end
            st   = '0;
            used = '0;
        end

        if (cnt != '0) begin
            res[ResIdxW'(cnt - 3'd1)].run_last = 1'b1;
        end

        o_res   = res;
        o_count = cnt;
        o_state = st;
        o_used  = used;
    end

endmodule

// File: sv/dmadb_result_buf.sv
// Result buffer: holds one segment's results and drains them one per cycle while the sink is ready.
`timescale 1ns / 1ps
module dmadb_result_buf (
    input  logic                                       i_clk,
    input  logic                                       i_rst_n,
    input  logic                                       i_load,
    input  dmadb_pkg::t_res [dmadb_pkg::MaxResults-1:0] i_res,
    input  logic [dmadb_pkg::ResCntW-1:0]              i_count,
    output logic                                       o_free,
    dmadb_entry_if.source                              o_entry
);
    import dmadb_pkg::*;

    t_res [MaxResults-1:0] r_res;
    logic [ResCntW-1:0]    r_left;
    logic [ResIdxW-1:0]    r_idx;
    logic                  take;
    t_res                  cur;

    assign take   = o_entry.valid && o_entry.ready;
    assign o_free = (r_left == '0) || (r_left == 3'd1 && take);
    assign cur    = r_res[r_idx];

    assign o_entry.valid        = r_left != '0;
    assign o_entry.entry_addr   = cur.entry_addr;
    assign o_entry.entry_bytes  = cur.entry_bytes;
    assign o_entry.end_of_table = cur.end_of_table;
    assign o_entry.status       = cur.status;
    assign o_entry.run_last     = cur.run_last;

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= '0;
            r_idx  <= '0;
        end else if (i_load) begin
            r_left <= i_count;
            r_idx  <= '0;
        end else if (take) begin
            r_left <= r_left - 3'd1;
            r_idx  <= r_idx + 2'd1;
        end
    end

endmodule

// File: sv/dmadb_checker.sv
// Port-level checks on the descriptor result stream, bound to the top level.
`timescale 1ns / 1ps
module dmadb_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [31:0] i_entry_addr,
    input logic [16:0] i_entry_bytes,
    input logic        i_end_of_table,
    input logic [1:0]  i_status,
    input logic        i_run_last
);
    import dmadb_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_entry_addr) &&
        $stable(i_entry_bytes) && $stable(i_end_of_table) && $stable(i_status) &&
        $stable(i_run_last))
        else $error("result transaction changed while stalled");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid straight after reset");

    a_error_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_status != ST_DESC |->
        i_entry_addr == 32'd0 && i_entry_bytes == 17'd0 && !i_end_of_table && i_run_last)
        else $error("malformed error result");

    a_eot_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_end_of_table |-> i_run_last && i_status == ST_DESC)
        else $error("end of table not on last result of a segment");

    a_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_status == ST_DESC |->
        i_entry_bytes != 17'd0 &&
        ({2'b00, i_entry_addr[15:0]} + {1'b0, i_entry_bytes}) <= WindowBytes)
        else $error("descriptor empty or crossing a 64 KiB boundary");

endmodule

bind dma_descriptor_builder dmadb_checker u_dmadb_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_out_valid    (o_entry.valid),
    .i_out_ready    (o_entry.ready),
    .i_entry_addr   (o_entry.entry_addr),
    .i_entry_bytes  (o_entry.entry_bytes),
    .i_end_of_table (o_entry.end_of_table),
    .i_status       (o_entry.status),
    .i_run_last     (o_entry.run_last)
);

// File: tb/tb.sv
// Testbench for dma_descriptor_builder: drives segments and checks descriptors.
`timescale 1ns / 1ps
module tb;
    import dmadb_pkg::*;

    localparam int unsigned TableEntries = 256;
    localparam int unsigned RandomItems  = 260;
    localparam int unsigned StallLimit   = 3000;
    localparam int unsigned DrainSlack   = 8;
    localparam int unsigned HoldCycles   = 300;

    logic i_clk;
    logic i_rst_n;

    dmadb_seg_if   seg_bus ();
    dmadb_entry_if entry_bus ();

    dma_descriptor_builder #(
        .TABLE_ENTRIES     (TableEntries),
        .MAX_SEGMENT_BYTES (131072)
    ) uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_seg   (seg_bus),
        .o_entry (entry_bus)
    );

    // table state as the block should hold it
    logic [31:0] tbl_start;
    logic [16:0] tbl_len;
    logic        tbl_open;
    logic        tbl_sealed;
    logic        tbl_failed;
    int unsigned tbl_used;

    t_res pending_entries[$];

    int  fail_count    = 0;
    int  segs_sent     = 0;
    int  results_seen  = 0;
    int  overflow_seen = 0;
    int  empty_seen    = 0;
    int  stall_cycles  = 0;
    int  sink_hold_cycles = 0;
    bit  src_idle_on  = 1'b1;
    bit  sink_idle_on = 1'b1;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic void clear_table();
        tbl_start  = '0;
        tbl_len    = '0;
        tbl_open   = 1'b0;
        tbl_sealed = 1'b0;
        tbl_failed = 1'b0;
        tbl_used   = 0;
    endfunction

    function automatic t_res make_entry(input logic [31:0] addr, input logic [16:0] nbytes,
                                        input logic eot, input t_status st);
        t_res r;
        r.entry_addr   = addr;
        r.entry_bytes  = nbytes;
        r.end_of_table = eot;
        r.status       = st;
        r.run_last     = 1'b0;
        return r;
    endfunction

    // Works out the descriptors one accepted segment gives and queues them.
    function automatic void build_descriptors(input t_seg s);
        logic [31:0] addr;
        logic [31:0] run_end;
        logic [17:0] rem;
        logic [17:0] room;
        logic [17:0] take;
        t_res        r;
        int          n;
        n    = 0;
        addr = s.seg_addr;
        rem  = (s.seg_bytes > HardSegLimit) ? HardSegLimit : s.seg_bytes;
        if (!tbl_failed) begin
            if (rem == 0 && tbl_open && addr != tbl_start + {15'b0, tbl_len})
                tbl_sealed = 1'b1;
            while (rem != 0) begin
                room    = WindowBytes - {2'b00, addr[15:0]};
                take    = (room < rem) ? room : rem;
                run_end = tbl_start + {15'b0, tbl_len};
                if (tbl_open && !tbl_sealed && addr == run_end && run_end[15:0] != 16'h0) begin
                    tbl_len = tbl_len + take[16:0];
                end else begin
                    if (tbl_used + 1 >= TableEntries) begin
                        tbl_open   = 1'b0;
                        tbl_failed = 1'b1;
                        pending_entries.push_back(make_entry('0, '0, 1'b0, ST_OVERFLOW));
                        n++;
                        break;
                    end
                    if (tbl_open) begin
                        pending_entries.push_back(make_entry(tbl_start, tbl_len, 1'b0, ST_DESC));
                        n++;
                    end
                    tbl_used++;
                    tbl_start  = addr;
                    tbl_len    = take[16:0];
                    tbl_open   = 1'b1;
                    tbl_sealed = 1'b0;
                end
                addr = addr + {14'b0, take};
                rem  = rem - take;
            end
        end
        if (s.seg_last) begin
            if (!tbl_failed) begin
                if (tbl_open)
                    pending_entries.push_back(make_entry(tbl_start, tbl_len, 1'b1, ST_DESC));
                else
                    pending_entries.push_back(make_entry('0, '0, 1'b0, ST_EMPTY));
                n++;
            end
            clear_table();
        end
        if (n > 0) begin
            r = pending_entries.pop_back();
            r.run_last = 1'b1;
            pending_entries.push_back(r);
        end
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        fail_count++;
        if (fail_count <= 40)
            $display("mismatch at %0t: %s: got %0h, expected %0h", $time, what, got, want);
    endtask

    // Returns just after the acceptance edge; valid is settled at the next falling edge.
    task automatic send_segment(input logic [31:0] addr, input logic [17:0] nbytes,
                                input logic last);
        t_seg s;
        s.seg_addr  = addr;
        s.seg_bytes = nbytes;
        s.seg_last  = last;
        @(negedge i_clk);
        while (src_idle_on && $urandom_range(0, 99) < 17) begin
            seg_bus.valid <= 1'b0;
            @(negedge i_clk);
        end
        seg_bus.valid     <= 1'b1;
        seg_bus.seg_addr  <= s.seg_addr;
        seg_bus.seg_bytes <= s.seg_bytes;
        seg_bus.seg_last  <= s.seg_last;
        do @(posedge i_clk); while (!seg_bus.ready);
        build_descriptors(s);
        segs_sent++;
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        seg_bus.valid <= 1'b0;
        while (pending_entries.size() != 0) @(posedge i_clk);
        repeat (DrainSlack) @(posedge i_clk);
    endtask

    task automatic test_directed();
        send_segment(32'h0000_0000, 18'd0, 1'b1);          // empty request
        send_segment(32'hffff_ffff, 18'd1, 1'b1);
        send_segment(32'hffff_fffe, 18'd4, 1'b1);          // wraps through zero
        send_segment(32'h0000_1000, 18'h100, 1'b0);        // contiguous merge
        send_segment(32'h0000_1100, 18'h200, 1'b1);
        send_segment(32'h0000_2000, 18'h10, 1'b0);         // gap
        send_segment(32'h0000_3000, 18'h10, 1'b1);
        send_segment(32'h0000_4000, 18'h20, 1'b0);         // zero bytes elsewhere seals
        send_segment(32'h0000_9998, 18'd0, 1'b0);
        send_segment(32'h0000_4020, 18'h20, 1'b1);
        send_segment(32'h0000_5000, 18'h20, 1'b0);         // zero bytes at run end
        send_segment(32'h0000_5020, 18'd0, 1'b0);
        send_segment(32'h0000_5020, 18'h20, 1'b1);
        send_segment(32'h0001_fff0, 18'h20, 1'b1);         // 64 KiB split
        send_segment(32'h0002_0000, 18'h10000, 1'b0);      // full window
        send_segment(32'h0003_0000, 18'h10, 1'b1);
        send_segment(32'h0001_0002, 18'h3ffff, 1'b1);      // saturated length
        send_segment(32'h0000_0100, 18'd2, 1'b0);          // four results from one
        send_segment(32'h0001_8000, 18'h20000, 1'b1);
        send_segment(32'h0000_7001, 18'd3, 1'b0);          // odd address and size
        send_segment(32'h0000_7004, 18'd5, 1'b1);
        send_segment(32'h0000_6000, 18'd0, 1'b0);
        send_segment(32'h0000_6000, 18'd0, 1'b1);
        send_segment(32'haaaa_5554, 18'h20001, 1'b1);
        send_segment(32'h5555_aaab, 18'h15555, 1'b1);
    endtask

    // 85 segments of three descriptors each fill the table exactly
    task automatic test_full_table();
        int i;
        for (i = 0; i < 85; i++)
            send_segment(32'(i) * 32'h0010_0000 + 32'h0000_8000, 18'h20000, 1'b0);
        send_segment(32'hc000_0000, 18'd0, 1'b1);
        wait_drained();
    endtask

    task automatic test_table_overflow();
        int i;
        sink_hold_cycles = HoldCycles;
        for (i = 0; i < 85; i++)
            send_segment(32'h8000_8000 + 32'(i) * 32'h0010_0000, 18'h20000, 1'b0);
        send_segment(32'hf000_0000, 18'd64, 1'b0);        // overflows
        send_segment(32'hf100_0000, 18'd100, 1'b0);       // discarded
        send_segment(32'hf200_0000, 18'd0, 1'b1);
        send_segment(32'h0000_0040, 18'd8, 1'b1);          // next request is clean
        wait_drained();
    endtask

    task automatic test_random();
        logic [31:0] next_addr;
        logic [31:0] a;
        logic [17:0] b;
        int          sent;
        int          segs;
        int          k;
        int          r;
        sent = 0;
        src_idle_on  = 1'b0;
        sink_idle_on = 1'b0;
        while (sent < RandomItems) begin
            if (sent >= 90) begin
                src_idle_on  = 1'b1;
                sink_idle_on = 1'b1;
            end
            segs      = $urandom_range(1, 8);
            next_addr = $urandom;
            for (k = 0; k < segs; k++) begin
                r = $urandom_range(0, 99);
                if (r < 55) begin
                    a = next_addr;
                end else if (r < 70) begin
                    a = $urandom;
                    a[15:0] = 16'(17'h10000 - 2 * $urandom_range(1, 64));
                end else if (r < 92) begin
                    a = $urandom;
                    a[0] = 1'b0;
                end else begin
                    a = $urandom;
                end
                r = $urandom_range(0, 99);
                if (r < 45)
                    b = 18'(2 * $urandom_range(1, 1024));
                else if (r < 60)
                    b = '0;
                else if (r < 78)
                    b = 18'(2 * $urandom_range(1, 32768));
                else if (r < 92)
                    b = 18'($urandom_range(0, 131072));
                else
                    b = 18'($urandom_range(131073, 262143));
                send_segment(a, b, k == segs - 1);
                next_addr = a + {14'b0, b};
                sent++;
            end
            if ($urandom_range(0, 11) == 0)
                wait_drained();
        end
    endtask

    initial begin : sink_pacing
        int n;
        forever begin
            @(negedge i_clk);
            if (sink_hold_cycles != 0) begin
                n = sink_hold_cycles;
                sink_hold_cycles = 0;
                entry_bus.ready <= 1'b0;
                repeat (n - 1) @(negedge i_clk);
            end else begin
                entry_bus.ready <= !(sink_idle_on && $urandom_range(0, 99) < 17);
            end
        end
    end

    always @(posedge i_clk) begin : check_entries
        t_res want;
        if (i_rst_n && entry_bus.valid && entry_bus.ready) begin
            results_seen++;
            if (pending_entries.size() == 0) begin
                report_mismatch("result with none expected", entry_bus.entry_addr, '0);
            end else begin
                want = pending_entries.pop_front();
                if (want.status == ST_OVERFLOW)
                    overflow_seen++;
                if (want.status == ST_EMPTY)
                    empty_seen++;
                if (entry_bus.entry_addr !== want.entry_addr)
                    report_mismatch("entry_addr", entry_bus.entry_addr, want.entry_addr);
                if (entry_bus.entry_bytes !== want.entry_bytes)
                    report_mismatch("entry_bytes", 32'(entry_bus.entry_bytes),
                                    32'(want.entry_bytes));
                if (entry_bus.end_of_table !== want.end_of_table)
                    report_mismatch("end_of_table", 32'(entry_bus.end_of_table),
                                    32'(want.end_of_table));
                if (entry_bus.status !== want.status)
                    report_mismatch("status", 32'(entry_bus.status), 32'(want.status));
                if (entry_bus.run_last !== want.run_last)
                    report_mismatch("run_last", 32'(entry_bus.run_last), 32'(want.run_last));
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (seg_bus.valid && seg_bus.ready) ||
            (entry_bus.valid && entry_bus.ready)) begin
            stall_cycles = 0;
        end else begin
            stall_cycles++;
            if (stall_cycles >= StallLimit) begin
                $display("watchdog: no transaction for %0d cycles", StallLimit);
                $display("status: fail");
                $finish;
            end
        end
    end

    initial begin
        i_rst_n           = 1'b0;
        seg_bus.valid     = 1'b0;
        seg_bus.seg_addr  = '0;
        seg_bus.seg_bytes = '0;
        seg_bus.seg_last  = 1'b0;
        entry_bus.ready   = 1'b0;
        clear_table();
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        wait_drained();
        test_full_table();
        test_table_overflow();
        test_random();
        wait_drained();

        $display("%0d segments sent, %0d descriptor results checked", segs_sent, results_seen);
        $display("%0d table overflows, %0d empty requests, %0d mismatches",
                 overflow_seen, empty_seen, fail_count);
        if (fail_count == 0 && pending_entries.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
